// ===== hw/rtl/bsbi_pkg.sv =====
// Shared types and constants for the bit-sliced Bloom filter insert block.
// Holds request and response payload structs, register indexes and hash primes.
// No dependencies.
`timescale 1ns / 1ps

package bsbi_pkg;

    // Default store geometry
    localparam int ROWS_DEF       = 65536;
    localparam int DOCS_DEF       = 64;
    localparam int MAX_HASHES_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int KMER_BYTES     = 8;

    // Configuration register layout
    localparam int SIG_W       = 17;
    localparam int NHASH_W     = 5;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNATURE_SIZE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_HASHES     = 1'd1;
    localparam logic [SIG_W-1:0]       SIG_RESET          = 17'd65536;
    localparam logic [NHASH_W-1:0]     NHASH_RESET        = 5'd1;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // XXH32 primes
    localparam logic [31:0] PR2 = 32'd2246822519;
    localparam logic [31:0] PR3 = 32'd3266489917;
    localparam logic [31:0] PR4 = 32'd668265263;
    localparam logic [31:0] PR5 = 32'd374761393;

    typedef struct packed {
        logic        operation;
        logic [63:0] kmer;
        logic [5:0]  doc_index;
        logic [15:0] read_row;
    } req_t;

    typedef struct packed {
        logic [15:0] row_index;
        logic [63:0] row_bits;
        logic        last;
    } rsp_t;

    // Command to the hash unit
    typedef struct packed {
        logic        start;
        logic [63:0] kmer;
        logic [31:0] seed;
    } hash_cmd_t;

endpackage

// ===== hw/rtl/bsbi_hash.sv =====
// Seeded XXH32 of a 64-bit k-mer followed by reduction modulo the row count.
// One shared 32x32 multiplier for the mix rounds, then a bit-serial remainder.
// Depends on bsbi_pkg.
`timescale 1ns / 1ps

module bsbi_hash #(
    parameter int AW = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bsbi_pkg::hash_cmd_t cmd,
    input  logic [AW:0]       modulus,
    output logic              done,
    output logic [AW-1:0]     row
);
    import bsbi_pkg::*;

    typedef enum logic [2:0] {
        HS_IDLE = 3'b001,
        HS_MIX  = 3'b010,
        HS_DIV  = 3'b100
    } hstate_t;

    hstate_t        state_reg, state_next;
    logic [2:0]     step_reg, step_next;
    logic [4:0]     bit_reg, bit_next;
    logic [31:0]    acc_reg, acc_next;
    logic [31:0]    dvd_reg, dvd_next;
    logic [AW-1:0]  rem_reg, rem_next;
    logic [63:0]    kmer_reg, kmer_next;
    logic [31:0]    seed_reg, seed_next;
    logic           done_reg, done_next;

    logic [31:0]    op_a, op_b, addend, prod;
    logic [AW:0]    trial;

    // Select multiplier operands for each mix round
    always_comb
    begin
        op_a   = acc_reg;
        op_b   = PR4;
        addend = '0;
        case (step_reg)
            3'd0:
            begin
                op_a   = kmer_reg[31:0];
                op_b   = PR3;
                addend = seed_reg + PR5 + 32'(KMER_BYTES);
            end
            3'd1, 3'd3:
            begin
                op_a = {acc_reg[14:0], acc_reg[31:15]};
                op_b = PR4;
            end
            3'd2:
            begin
                op_a   = kmer_reg[63:32];
                op_b   = PR3;
                addend = acc_reg;
            end
            3'd4:
            begin
                op_a = acc_reg ^ (acc_reg >> 15);
                op_b = PR2;
            end
            3'd5:
            begin
                op_a = acc_reg ^ (acc_reg >> 13);
                op_b = PR3;
            end
            default:
            begin
                op_a = acc_reg;
                op_b = PR4;
            end
        endcase
        prod = op_a * op_b;
    end

    assign trial = {rem_reg, dvd_reg[31]};

    // Sequence mix rounds, then one remainder bit per cycle
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        acc_next   = acc_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        kmer_next  = kmer_reg;
        seed_next  = seed_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            HS_IDLE:
            begin
                if (cmd.start)
                begin
                    kmer_next  = cmd.kmer;
                    seed_next  = cmd.seed;
                    step_next  = '0;
                    state_next = HS_MIX;
                end
            end
            HS_MIX:
            begin
                if (step_reg == 3'd6)
                begin
                    dvd_next   = acc_reg ^ (acc_reg >> 16);
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = HS_DIV;
                end
                else
                begin
                    acc_next  = prod + addend;
                    step_next = step_reg + 3'd1;
                end
            end
            HS_DIV:
            begin
                dvd_next = {dvd_reg[30:0], 1'b0};
                if (trial >= modulus)
                    rem_next = AW'(trial - modulus);
                else
                    rem_next = trial[AW-1:0];
                bit_next = bit_reg + 5'd1;
                if (bit_reg == 5'd31)
                begin
                    done_next  = 1'b1;
                    state_next = HS_IDLE;
                end
            end
            default:
            begin
                state_next = HS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        kmer_reg <= kmer_next;
        seed_reg <= seed_next;
    end

    assign done = done_reg;
    assign row  = rem_reg;

    // The remainder stays below the modulus
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, rem_reg} < modulus))
        else $error("remainder not below modulus");

    // A start is only taken while idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && state_reg != HS_IDLE) |-> 1'b0)
        else $error("hash start while busy");

endmodule

// ===== hw/rtl/bitsliced_bloom_insert.sv =====
// Top level of the bit-sliced Bloom filter insert block.
// Owns the row store, configuration registers and the request sequencer.
// Depends on bsbi_pkg and bsbi_hash.
`timescale 1ns / 1ps

// After reset the block clears the store one row per cycle and holds
// req_stall high meanwhile (configuration writes are taken). An insert
// request, once accepted, runs one round per configured hash. Each round
// starts the hash unit, runs XXH32 mixing on one shared multiplier, takes a
// bit-serial remainder by the row count in use, hands the row over, then does
// one memory read and one read-modify-write of that row. A stalled response
// holds the write step of the next round until the output register frees. A
// read request passes through the read and update steps. One request is in
// work at a time; a response waits in the output register while the next
// round proceeds.
module bitsliced_bloom_insert #(
    parameter int ROWS       = bsbi_pkg::ROWS_DEF,
    parameter int DOCS       = bsbi_pkg::DOCS_DEF,
    parameter int MAX_HASHES = bsbi_pkg::MAX_HASHES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  bsbi_pkg::req_t               req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output bsbi_pkg::rsp_t               rsp_data,
    input  logic                         cfg_write,
    input  logic [bsbi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsbi_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsbi_pkg::*;

    localparam int AW     = $clog2(ROWS);
    localparam int HCOUNT = (MAX_HASHES < MAX_RESULTS) ? MAX_HASHES : MAX_RESULTS;
    localparam int HW     = $clog2(HCOUNT + 1);

    typedef enum logic [4:0] {
        T_CLEAR  = 5'b00001,
        T_IDLE   = 5'b00010,
        T_HASH   = 5'b00100,
        T_READ   = 5'b01000,
        T_UPDATE = 5'b10000
    } tstate_t;

    tstate_t          state_reg;
    logic [SIG_W-1:0]   sig_reg;
    logic [NHASH_W-1:0] nhash_reg;
    logic [AW-1:0]    clr_reg;
    logic [HW-1:0]    h_reg;
    logic             start_reg;
    logic             is_read_reg;
    logic             in_range_reg;
    logic [63:0]      kmer_reg;
    logic [5:0]       doc_reg;
    logic [AW-1:0]    row_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_data_reg;

    logic [DOCS-1:0]  mem [ROWS];
    logic [DOCS-1:0]  rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [DOCS-1:0]  mem_wdata;

    logic [AW:0]      modulus;
    logic [HW-1:0]    count;
    logic             last;
    logic             slot_free;
    logic             rsp_load;
    logic             start_hash;
    logic [DOCS-1:0]  set_mask;
    logic [DOCS-1:0]  new_bits;
    hash_cmd_t        hcmd;
    logic             hash_done;
    logic [AW-1:0]    hash_row;

    // Clamp configuration to legal ranges
    always_comb
    begin
        if (sig_reg == '0)
            modulus = (AW + 1)'(1);
        else if (32'(sig_reg) > ROWS)
            modulus = (AW + 1)'(ROWS);
        else
            modulus = (AW + 1)'(sig_reg);
        if (nhash_reg == '0)
            count = HW'(1);
        else if (32'(nhash_reg) > HCOUNT)
            count = HW'(HCOUNT);
        else
            count = HW'(nhash_reg);
    end

    assign last      = (h_reg + HW'(1)) == count;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_load  = (state_reg == T_UPDATE) && slot_free;
    assign start_hash = (state_reg == T_IDLE && req_valid && req_data.operation == OP_INSERT)
                     || (rsp_load && !is_read_reg && !last);
    assign set_mask  = (32'(doc_reg) < DOCS) ? ({{(DOCS-1){1'b0}}, 1'b1} << doc_reg) : '0;
    assign new_bits  = rd_data_reg | set_mask;

    assign hcmd.start = start_reg;
    assign hcmd.kmer  = kmer_reg;
    assign hcmd.seed  = 32'(h_reg);

    bsbi_hash #(
        .AW(AW)
    ) u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (hcmd),
        .modulus (modulus),
        .done    (hash_done),
        .row     (hash_row)
    );

    // Drive memory writes: zeros while clearing, merged row on insert
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = row_reg;
        mem_wdata = new_bits;
        if (state_reg == T_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == T_UPDATE && slot_free && !is_read_reg)
        begin
            mem_we = 1'b1;
        end
    end

    // Row store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[row_reg];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg   <= SIG_RESET;
            nhash_reg <= NHASH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SIGNATURE_SIZE: sig_reg   <= cfg_data[SIG_W-1:0];
                REG_NUM_HASHES:     nhash_reg <= cfg_data[NHASH_W-1:0];
                default: ;
            endcase
        end
    end

    // Request sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_CLEAR;
            clr_reg       <= '0;
            h_reg         <= '0;
            start_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= start_hash;
            rsp_valid_reg <= rsp_load || (rsp_valid_reg && rsp_stall);
            unique case (state_reg)
                T_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == ROWS - 1)
                        state_reg <= T_IDLE;
                end
                T_IDLE:
                begin
                    if (req_valid)
                    begin
                        h_reg <= '0;
                        if (req_data.operation == OP_READ)
                            state_reg <= T_READ;
                        else
                            state_reg <= T_HASH;
                    end
                end
                T_HASH:
                begin
                    if (hash_done)
                        state_reg <= T_READ;
                end
                T_READ:
                begin
                    state_reg <= T_UPDATE;
                end
                T_UPDATE:
                begin
                    if (slot_free)
                    begin
                        if (is_read_reg || last)
                            state_reg <= T_IDLE;
                        else
                        begin
                            h_reg     <= h_reg + HW'(1);
                            state_reg <= T_HASH;
                        end
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // Capture request fields, row address and response payload
    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && req_valid)
        begin
            is_read_reg  <= (req_data.operation == OP_READ);
            kmer_reg     <= req_data.kmer;
            doc_reg      <= req_data.doc_index;
            row_reg      <= AW'(req_data.read_row);
            in_range_reg <= (32'(req_data.read_row) < ROWS);
        end
        if (state_reg == T_HASH && hash_done)
            row_reg <= hash_row;
        if (state_reg == T_UPDATE && slot_free)
        begin
            rsp_data_reg.row_index <= 16'(row_reg);
            if (is_read_reg)
            begin
                rsp_data_reg.row_bits <= in_range_reg ? 64'(rd_data_reg) : '0;
                rsp_data_reg.last     <= 1'b1;
            end
            else
            begin
                rsp_data_reg.row_bits <= 64'(new_bits);
                rsp_data_reg.last     <= last;
            end
        end
    end

    assign req_stall = (state_reg != T_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // No response while the store is being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_CLEAR |-> !rsp_valid_reg)
        else $error("response during clear");

    // Hash results arrive only while waiting for them
    a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == T_HASH)
        else $error("unexpected hash result");

    // Round counter stays below the hash count
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_HASH |-> h_reg < count)
        else $error("round counter overrun");

    // A new response is loaded only from the update step
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == T_UPDATE)
        else $error("response loaded outside update");

endmodule
